@@ design/ps2mdec_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2mdec_pkg
// Shared types for the PS/2 mouse packet decoder with packet queue.
// ----------------------------------------------------------------------------
package ps2mdec_pkg;

  localparam int unsigned MoveW = 9;

  // decoded packet as kept in the queue, left button in bit 0
  typedef struct packed {
    logic [MoveW-1:0] move_y;
    logic [MoveW-1:0] move_x;
    logic             middle;
    logic             right;
    logic             left;
  } packet_t;

  localparam int unsigned PacketW = $bits(packet_t);

  // position of the next byte within a three byte packet
  typedef enum logic [1:0] {
    POS_FLAGS = 2'd0,
    POS_X     = 2'd1,
    POS_Y     = 2'd2
  } byte_pos_e;

  // queue status handed back for the word being processed
  typedef struct packed {
    logic taken;
    logic pending;
  } q_status_t;

endpackage

@@ design/ps2mdec_assembler.sv @@
// ----------------------------------------------------------------------------
// ps2mdec_assembler
// Gathers mouse bytes into three byte packets and decodes a finished packet.
// ----------------------------------------------------------------------------
module ps2mdec_assembler
  import ps2mdec_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    byte_en_i,
  input  logic [7:0] rx_byte_i,
  output logic    push_o,
  output packet_t push_word_o
);

  byte_pos_e  pos_q, pos_d;
  logic [7:0] flags_q, flags_d;
  logic [7:0] held_x_q, held_x_d;

  function automatic logic [MoveW-1:0] axis_value(input logic [7:0] raw,
                                                  input logic sign_bit,
                                                  input logic ovf_bit);
    logic [MoveW-1:0] res;
    res = ovf_bit ? '0 : {sign_bit, raw};
    return res;
  endfunction

  always_comb begin
    pos_d    = pos_q;
    flags_d  = flags_q;
    held_x_d = held_x_q;
    push_o   = 1'b0;

    push_word_o.left   = flags_q[0];
    push_word_o.right  = flags_q[1];
    push_word_o.middle = flags_q[2];
    push_word_o.move_x = axis_value(held_x_q, flags_q[4], flags_q[6]);
    push_word_o.move_y = axis_value(rx_byte_i, flags_q[5], flags_q[7]);

    if (byte_en_i) begin
      case (pos_q)
        POS_X: begin
          held_x_d = rx_byte_i;
          pos_d    = POS_Y;
        end
        POS_Y: begin
          push_o = 1'b1;
          pos_d  = POS_FLAGS;
        end
        default: begin
          // a first byte without the always-one bit is dropped to resync
          if (rx_byte_i[3]) begin
            flags_d = rx_byte_i;
            pos_d   = POS_X;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_FLAGS;
      flags_q  <= '0;
      held_x_q <= '0;
    end else begin
      pos_q    <= pos_d;
      flags_q  <= flags_d;
      held_x_q <= held_x_d;
    end
  end

endmodule

@@ design/ps2mdec_queue.sv @@
// ----------------------------------------------------------------------------
// ps2mdec_queue
// Ring queue of decoded packets, one slot kept free, with registered read.
// ----------------------------------------------------------------------------
module ps2mdec_queue
  import ps2mdec_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  packet_t   push_word_i,
  input  logic      pop_i,
  output q_status_t status_o,
  output packet_t   rd_word_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PtrW-1:0] LastIdx = PtrW'(QUEUE_DEPTH - 1);

  packet_t         mem [QUEUE_DEPTH];
  packet_t         rd_word_q;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_next, rd_next;
  logic            push_ok, pop_ok;

  assign wr_next = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
  assign rd_next = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;

  // full packets are dropped silently, empty reads just report nothing
  assign push_ok = push_i && (wr_next != rd_ptr_q);
  assign pop_ok  = pop_i && (wr_ptr_q != rd_ptr_q);

  assign wr_ptr_d = push_ok ? wr_next : wr_ptr_q;
  assign rd_ptr_d = pop_ok ? rd_next : rd_ptr_q;

  assign status_o.taken   = pop_ok;
  assign status_o.pending = (wr_ptr_d != rd_ptr_d);
  assign rd_word_o        = rd_word_q;

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[wr_ptr_q] <= push_word_i;
    end
    if (pop_ok) begin
      rd_word_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

endmodule

@@ design/ps2_mouse_packet_decoder_fifo.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder_fifo
// PS/2 mouse 3-byte packet decoder feeding a packet queue.
// ----------------------------------------------------------------------------
// Usage:
// - the slave stream carries one word per request: tuser 0 means tdata holds
//   a byte from the mouse, tuser 1 asks to take the oldest decoded packet
// - the master stream returns exactly one word per request; tuser marks a
//   packet actually taken, otherwise the packet fields read as zero; the
//   pending bit tells whether packets remain queued after that request
// - an accepted word waits in the input register and is processed as it
//   moves into the result register, which drives the output
// - one word per cycle is sustained unless the receiver stalls; the input
//   and result registers form two stages; the queue read port is registered
// - the queue holds QUEUE_DEPTH-1 packets; packets arriving when full are
//   dropped without notice
// - reset empties the queue and restarts byte gathering; queue memory is not
//   cleared, which is never observed since empty slots are never read
// - when the receiver stalls the result holds, the input stage fills, and
//   s_axis_tready_o falls until the result is taken
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder_fifo
  import ps2mdec_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  input  logic        s_axis_tuser_i,  // [0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] left_pressed, [1] right_pressed, [2] middle_pressed,
  // [11:3] move_x, [20:12] move_y, [21] pending, [23:22] zero
  output logic [23:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o   // [0] taken_valid
);

  logic       s1_valid_q, s1_mode_q;
  logic [7:0] s1_byte_q;
  logic       s2_valid_q, s2_taken_q, s2_pending_q;
  logic       s2_ready, adv;
  logic       asm_push;
  packet_t    asm_word, rd_word, out_word;
  q_status_t  q_status;

  assign s2_ready        = !s2_valid_q || m_axis_tready_i;
  assign adv             = s1_valid_q && s2_ready;
  assign s_axis_tready_o = !s1_valid_q || s2_ready;

  ps2mdec_assembler u_assembler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_en_i   (adv && !s1_mode_q),
    .rx_byte_i   (s1_byte_q),
    .push_o      (asm_push),
    .push_word_o (asm_word)
  );

  ps2mdec_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (asm_push),
    .push_word_i (asm_word),
    .pop_i       (adv && s1_mode_q),
    .status_o    (q_status),
    .rd_word_o   (rd_word)
  );

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      s1_mode_q <= s_axis_tuser_i;
      s1_byte_q <= s_axis_tdata_i;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_taken_q   <= q_status.taken;
      s2_pending_q <= q_status.pending;
    end
  end

  assign out_word        = s2_taken_q ? rd_word : '0;
  assign m_axis_tvalid_o = s2_valid_q;
  assign m_axis_tuser_o  = s2_taken_q;
  assign m_axis_tdata_o  = {2'b00, s2_pending_q, out_word};

`ifndef SYNTH
  // input side only stalls when the result stage is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> s1_valid_q && s2_valid_q && !m_axis_tready_i)
    else $error("input stalled without output back-pressure");

  // a byte word never reports a taken packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !s1_mode_q |=> !s2_taken_q)
    else $error("byte word reported a taken packet");

  // push and pop never fall in the same step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(asm_push && q_status.taken))
    else $error("queue push and pop in the same step");

  // a packet is taken from the queue only on a read request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.taken |-> adv && s1_mode_q)
    else $error("queue popped without a read request");
`endif

endmodule

@@ dv/tb_ps2_mouse_packet_decoder_fifo.sv @@
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_decoder_fifo
// Stream-level testbench for the PS/2 mouse packet decoder and packet queue.
// Mouse bytes and read requests go in on the slave stream. Every accepted
// word is run through a local decoder and queue model. The word that model
// returns is compared field by field with the next word on the master
// stream. Both sides stall at random, and one phase fills the queue past
// its capacity.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_decoder_fifo;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2mdec_pkg::*;

  localparam int unsigned QueueDepth  = 64;
  localparam int unsigned ClkPeriod   = 4;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned TotalWords  = 1550;
  localparam int unsigned MaxReports  = 10;

  localparam bit MODE_BYTE = 1'b0;
  localparam bit MODE_READ = 1'b1;

  localparam logic [7:0] BTN_LEFT    = 8'h01;
  localparam logic [7:0] BTN_RIGHT   = 8'h02;
  localparam logic [7:0] BTN_MIDDLE  = 8'h04;
  localparam logic [7:0] FLAG_SYNC   = 8'h08;
  localparam logic [7:0] FLAG_X_SIGN = 8'h10;
  localparam logic [7:0] FLAG_Y_SIGN = 8'h20;
  localparam logic [7:0] FLAG_X_OVF  = 8'h40;
  localparam logic [7:0] FLAG_Y_OVF  = 8'h80;

  typedef struct packed {
    logic    taken;
    logic    pending;
    packet_t pkt;
  } mouse_result_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  // decoder model state
  byte_pos_e     gather_pos   = POS_FLAGS;
  logic [7:0]    gather_flags = '0;
  logic [7:0]    gather_x     = '0;
  packet_t       pkt_queue[$];
  mouse_result_t expected_results[$];

  bit sender_idle = 1'b0;
  bit sink_idle   = 1'b0;
  int words_sent  = 0;
  int mismatches  = 0;

  ps2_mouse_packet_decoder_fifo #(
    .QUEUE_DEPTH(QueueDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic logic [MoveW-1:0] axis_move(logic [7:0] raw, logic [7:0] flags,
                                                 logic [7:0] sign_mask, logic [7:0] ovf_mask);
    if ((flags & ovf_mask) != 0) return '0;
    return {((flags & sign_mask) != 0), raw};
  endfunction

  function automatic mouse_result_t decode_step(bit mode, logic [7:0] b);
    mouse_result_t res;
    packet_t       pkt;
    res = '0;
    if (mode == MODE_BYTE) begin
      case (gather_pos)
        POS_X: begin
          gather_x   = b;
          gather_pos = POS_Y;
        end
        POS_Y: begin
          pkt.left   = (gather_flags & BTN_LEFT) != 0;
          pkt.right  = (gather_flags & BTN_RIGHT) != 0;
          pkt.middle = (gather_flags & BTN_MIDDLE) != 0;
          pkt.move_x = axis_move(gather_x, gather_flags, FLAG_X_SIGN, FLAG_X_OVF);
          pkt.move_y = axis_move(b, gather_flags, FLAG_Y_SIGN, FLAG_Y_OVF);
          gather_pos = POS_FLAGS;
          // one slot of the ring stays free, a full queue drops the packet
          if (pkt_queue.size() < QueueDepth - 1) pkt_queue.push_back(pkt);
        end
        default: begin
          // out of sync first byte is dropped
          if ((b & FLAG_SYNC) != 0) begin
            gather_flags = b;
            gather_pos   = POS_X;
          end
        end
      endcase
    end else if (pkt_queue.size() != 0) begin
      res.taken = 1'b1;
      res.pkt   = pkt_queue.pop_front();
    end
    res.pending = pkt_queue.size() != 0;
    return res;
  endfunction

  task automatic send_word(bit mode, logic [7:0] b);
    int gap;
    gap = sender_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= b;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    expected_results.push_back(decode_step(mode, b));
    words_sent++;
  endtask

  task automatic send_packet(logic [7:0] flags, logic [7:0] dx, logic [7:0] dy);
    send_word(MODE_BYTE, flags);
    send_word(MODE_BYTE, dx);
    send_word(MODE_BYTE, dy);
  endtask

  // the sender lets go of the bus while results drain
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("mismatch %s: expected 0x%0h, got 0x%0h at %0t", name, want, got, $realtime);
    end
  endtask

  // result sink and checker
  initial begin : result_sink
    int            stall;
    mouse_result_t got;
    mouse_result_t want;
    @(posedge rst_ni);
    forever begin
      stall = sink_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk_i);
      while (!m_axis_tvalid) @(negedge clk_i);
      got.taken   = m_axis_tuser;
      got.pending = m_axis_tdata[21];
      got.pkt     = m_axis_tdata[PacketW-1:0];
      @(posedge clk_i);
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result word 0x%0h at %0t", m_axis_tdata, $realtime);
      end else begin
        want = expected_results.pop_front();
        check_field("taken_valid", int'(want.taken), int'(got.taken));
        check_field("left_pressed", int'(want.pkt.left), int'(got.pkt.left));
        check_field("right_pressed", int'(want.pkt.right), int'(got.pkt.right));
        check_field("middle_pressed", int'(want.pkt.middle), int'(got.pkt.middle));
        check_field("move_x", int'(want.pkt.move_x), int'(got.pkt.move_x));
        check_field("move_y", int'(want.pkt.move_y), int'(got.pkt.move_y));
        check_field("pending", int'(want.pending), int'(got.pending));
      end
    end
  end

  // ends the run when neither side has moved a word for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= IdleLimit) begin
        $display("tb_ps2_mouse_packet_decoder_fifo: done, errors");
        $finish;
      end
    end
  end

  task automatic test_directed();
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    send_word(MODE_READ, 8'hFF);  // read on empty queue, tdata ignored
    send_word(MODE_BYTE, 8'hF7);  // sync bit clear, dropped
    send_word(MODE_BYTE, 8'h00);
    send_packet(FLAG_SYNC | BTN_LEFT | BTN_RIGHT | BTN_MIDDLE | FLAG_X_SIGN | FLAG_Y_SIGN,
                8'h00, 8'h00);
    send_packet(FLAG_SYNC, 8'hFF, 8'hFF);
    send_packet(FLAG_SYNC | FLAG_X_OVF | FLAG_Y_OVF | FLAG_X_SIGN | FLAG_Y_SIGN | BTN_LEFT,
                8'h55, 8'hAA);
    send_packet(FLAG_SYNC | FLAG_X_SIGN | FLAG_Y_SIGN | FLAG_Y_OVF, 8'hFF, 8'h01);
    repeat (5) send_word(MODE_READ, 8'h00);
  endtask

  task automatic test_queue_full();
    wait_for_drain();
    sender_idle = 1'b1;
    sink_idle   = 1'b1;
    repeat (QueueDepth + 2)
      send_packet(8'($urandom_range(0, 255)) | FLAG_SYNC, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    sender_idle = 1'b0;
    repeat (QueueDepth) send_word(MODE_READ, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_random();
    int  pick;
    bit  paused;
    paused = 1'b0;
    while (words_sent < TotalWords) begin
      if (words_sent % 200 < 3) begin
        sender_idle = $urandom_range(0, 3) != 0;
        sink_idle   = $urandom_range(0, 3) != 0;
      end
      if (!paused && words_sent >= 900) begin
        wait_for_drain();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55)
        send_packet(8'($urandom_range(0, 255)) | FLAG_SYNC, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      else if (pick < 90)
        repeat ($urandom_range(1, 4)) send_word(MODE_READ, 8'($urandom_range(0, 255)));
      else
        send_word(MODE_BYTE, 8'($urandom_range(0, 255)));  // noise, may break alignment
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_queue_full();
    test_random();
    wait_for_drain();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("tb_ps2_mouse_packet_decoder_fifo: done, clean");
    else
      $display("tb_ps2_mouse_packet_decoder_fifo: done, errors");
    $finish;
  end

endmodule
